// File: sv/pcmp_pkg.sv
// Shared types and constants for the pixel control message parser.
// No dependencies; the interfaces and the top level import this package.
`default_nettype none

package pcmp_pkg;

    localparam int unsigned DefMaxPixels = 512;
    localparam int unsigned DefNumStrips = 8;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_COMMAND = 2'd1;
    localparam logic [1:0] ERR_CHANNEL = 2'd2;
    localparam logic [1:0] ERR_LENGTH  = 2'd3;

    // Parse phase: four header bytes, then body bytes.
    typedef enum logic [2:0] {
        PH_CHAN,
        PH_CMD,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_BODY
    } phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       packet_start;
    } byte_beat_t;

    typedef struct packed {
        logic        write_enable;
        logic [2:0]  strip_index;
        logic [10:0] byte_offset;
        logic [7:0]  pixel_byte;
        logic        header_done;
        logic [1:0]  error_code;
        logic        message_end;
        logic        show_frame;
    } result_beat_t;

endpackage

`default_nettype wire

// File: sv/pcmp_byte_if.sv
// Valid/ready channel for the parser: payload bytes in; results use pcmp_result_if.
// Depends on pcmp_pkg for the beat types.
`default_nettype none

interface pcmp_byte_if import pcmp_pkg::*; ();
    logic       valid;
    logic       ready;
    byte_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: sv/pcmp_result_if.sv
// Valid/ready channel carrying one parse result per input byte.
// Depends on pcmp_pkg for the beat types.
`default_nettype none

interface pcmp_result_if import pcmp_pkg::*; ();
    logic         valid;
    logic         ready;
    result_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: sv/pixel_control_message_parser_top.sv
// Pixel control message parser top level; depends on pcmp_pkg, pcmp_byte_if, pcmp_result_if.
// A result is registered and is valid in the cycle after its byte is taken.
// Throughput: one byte per cycle; the single result register is the only stage,
// and a byte is taken whenever that register is empty or being drained.
// Reset (rst_n low, asynchronous) clears the parse state, the highest channel,
// the pending show request and the result valid.
`default_nettype none

module pixel_control_message_parser_top import pcmp_pkg::*; #(
    parameter int unsigned MAX_PIXELS = DefMaxPixels,
    parameter int unsigned NUM_STRIPS = DefNumStrips
) (
    input  wire            clk,
    input  wire            rst_n,
    pcmp_byte_if.sink      bytes,
    pcmp_result_if.source  results
);

    localparam logic [15:0] MaxLength = 16'(3 * MAX_PIXELS);
    localparam logic [7:0]  MaxChan   = 8'(NUM_STRIPS);

    phase_t       phase_reg, phase_next;
    logic [7:0]   channel_reg, channel_next;
    logic [7:0]   command_reg, command_next;
    logic [15:0]  length_reg, length_next;
    logic [15:0]  body_count_reg, body_count_next;
    logic         discard_reg, discard_next;
    logic         show_pending_reg, show_pending_next;
    logic [7:0]   highest_reg, highest_next;
    logic         res_valid_reg;
    result_beat_t res_reg, res_next;

    logic         accept;
    logic [7:0]   b;
    phase_t       phase_cur;
    logic [15:0]  body_cur;
    logic [7:0]   highest_cur;
    logic [15:0]  len_full;
    logic [1:0]   hdr_err;
    logic [7:0]   chan_fixed;
    logic [15:0]  body_inc;
    logic         body_last;
    logic         hdr_empty;

    assign bytes.ready  = !res_valid_reg || results.ready;
    assign accept       = bytes.valid && bytes.ready;
    assign b            = bytes.data.in_byte;
    assign results.valid = res_valid_reg;
    assign results.data  = res_reg;

    // A start-of-packet restarts the header and clears the highest channel.
    assign phase_cur   = bytes.data.packet_start ? PH_CHAN : phase_reg;
    assign body_cur    = bytes.data.packet_start ? 16'd0 : body_count_reg;
    assign highest_cur = bytes.data.packet_start ? 8'd0 : highest_reg;

    assign len_full  = {length_reg[15:8], b};
    assign hdr_empty = (len_full == 16'd0);
    assign body_inc  = body_cur + 16'd1;
    assign body_last = (body_inc >= length_reg);

    // Header checks in priority order; a bad channel is forced to one.
    always_comb
    begin
        hdr_err    = ERR_NONE;
        chan_fixed = channel_reg;
        priority if (command_reg != 8'd0)
        begin
            hdr_err = ERR_COMMAND;
        end
        else if (channel_reg == 8'd0 || channel_reg > MaxChan)
        begin
            hdr_err    = ERR_CHANNEL;
            chan_fixed = 8'd1;
        end
        else if (len_full > MaxLength)
        begin
            hdr_err = ERR_LENGTH;
        end
        else
        begin
            hdr_err = ERR_NONE;
        end
    end

    // Next phase
    always_comb
    begin
        unique case (phase_cur)
            PH_CHAN:   phase_next = PH_CMD;
            PH_CMD:    phase_next = PH_LEN_HI;
            PH_LEN_HI: phase_next = PH_LEN_LO;
            PH_LEN_LO: phase_next = hdr_empty ? PH_CHAN : PH_BODY;
            PH_BODY:   phase_next = body_last ? PH_CHAN : PH_BODY;
            default:   phase_next = PH_CHAN;
        endcase
    end

    // Datapath state and result
    always_comb
    begin
        channel_next      = channel_reg;
        command_next      = command_reg;
        length_next       = length_reg;
        body_count_next   = body_cur;
        discard_next      = discard_reg;
        show_pending_next = show_pending_reg;
        highest_next      = highest_cur;
        res_next          = '0;
        unique case (phase_cur)
            PH_CHAN:
            begin
                channel_next = b;
            end
            PH_CMD:
            begin
                command_next = b;
            end
            PH_LEN_HI:
            begin
                length_next = {b, 8'd0};
            end
            PH_LEN_LO:
            begin
                length_next          = len_full;
                channel_next         = chan_fixed;
                discard_next         = (hdr_err != ERR_NONE);
                body_count_next      = 16'd0;
                res_next.header_done = 1'b1;
                res_next.error_code  = hdr_err;
                res_next.message_end = hdr_empty;
                // Arm show even for a discarded message.
                if (chan_fixed >= highest_cur)
                begin
                    show_pending_next = 1'b1;
                    highest_next      = chan_fixed;
                end
            end
            PH_BODY:
            begin
                if (!discard_reg)
                begin
                    res_next.write_enable = 1'b1;
                    res_next.strip_index  = 3'(channel_reg - 8'd1);
                    res_next.byte_offset  = body_cur[10:0];
                    res_next.pixel_byte   = b;
                end
                body_count_next = body_inc;
                if (body_last)
                begin
                    res_next.message_end = 1'b1;
                    body_count_next      = 16'd0;
                    if (!discard_reg && show_pending_reg)
                    begin
                        res_next.show_frame = 1'b1;
                        show_pending_next   = 1'b0;
                    end
                end
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_CHAN;
            channel_reg      <= 8'd0;
            command_reg      <= 8'd0;
            length_reg       <= 16'd0;
            body_count_reg   <= 16'd0;
            discard_reg      <= 1'b0;
            show_pending_reg <= 1'b0;
            highest_reg      <= 8'd0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg        <= phase_next;
                channel_reg      <= channel_next;
                command_reg      <= command_next;
                length_reg       <= length_next;
                body_count_reg   <= body_count_next;
                discard_reg      <= discard_next;
                show_pending_reg <= show_pending_next;
                highest_reg      <= highest_next;
                res_valid_reg    <= 1'b1;
            end
            else if (results.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    a_err_with_header: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.data.error_code != ERR_NONE |-> results.data.header_done)
        else $error("error code without header completion");

    a_write_not_header: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.data.write_enable |-> !results.data.header_done)
        else $error("strip write on a header byte");

    a_show_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.data.show_frame |-> results.data.message_end)
        else $error("show request away from message end");

    a_start_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && bytes.data.packet_start |=> phase_reg == PH_CMD && res_valid_reg)
        else $error("start of packet did not restart the header");

endmodule

`default_nettype wire
